// ===== rtl/tetb_pkg.sv =====
// Shared types, constants and base64 coding functions of the event trace buffer.
package tetb_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned CAP_W         = 6;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ENTRY_W       = DATA_W + TAG_W;
  localparam int unsigned TEXT_W        = 64;
  localparam int unsigned NUM_CHARS     = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // base64 alphabet anchors
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  typedef enum logic [1:0] {
    ACT_REC_VALUE = 2'd0,
    ACT_REC_TIME  = 2'd1,
    ACT_FLUSH     = 2'd2,
    ACT_CLEAR     = 2'd3
  } tetb_action_e;

  // controller -> datapath
  typedef struct packed {
    logic rec_en;    // append an entry
    logic rec_ts;    // entry takes the timestamp instead of the value
    logic fill_clr;  // empty the buffer
    logic rd_en;     // read one entry for the dump
    logic rd_last;   // that entry closes the dump
  } tetb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic room;      // fill count below effective capacity
    logic rd_free;   // read stage can take an entry this cycle
  } tetb_sts_t;

  function automatic logic [7:0] b64_char(input logic [5:0] sextet);
    logic [7:0] s8;
    s8 = {2'b00, sextet};
    if (sextet < 6'd26)      return CH_UPPER_A + s8;
    else if (sextet < 6'd52) return CH_LOWER_A + s8 - 8'd26;
    else if (sextet < 6'd62) return CH_ZERO + s8 - 8'd52;
    else if (sextet == 6'd62) return CH_PLUS;
    else                     return CH_SLASH;
  endfunction

  function automatic logic [TEXT_W-1:0] b64_encode(input logic [ENTRY_W-1:0] entry);
    logic [TEXT_W-1:0] word;
    word = '0;
    for (int k = 0; k < NUM_CHARS; k++) begin
      word[TEXT_W-1-8*k -: 8] = b64_char(entry[ENTRY_W-1-6*k -: 6]);
    end
    return word;
  endfunction

endpackage

// ===== rtl/tagged_event_trace_buffer_unit.sv =====
// Tagged event trace buffer: record, clear and base64 dump of up to DEPTH entries.
// Record and clear items are accepted at one item per cycle while no dump stalls the input.
// A flush item with stored entries stalls the input while the entries are read;
// each entry passes the memory read register and then the encoded output register,
// and results follow one per cycle as long as the output side does not stall.
// Reset clears the fill count and the output valid flag, sets capacity to 32; memory is not cleared.
module tagged_event_trace_buffer_unit import tetb_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: capacity register
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [TAG_W-1:0]  tag_id_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] timestamp_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TEXT_W-1:0] text_o,
  output logic              last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Controller decodes the action and walks the read index during a dump.
  // Datapath owns the entry memory, the fill count and a two-deep output
  // pipe (memory read register, then encoded output register), so one more entry
  // can be read while a finished result waits for the consumer.
  tetb_cmd_t     cmd;
  tetb_sts_t     sts;
  logic [CW-1:0] fill;
  logic [AW-1:0] rd_addr;

  tetb_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .AW    (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .fill_i     (fill),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  tetb_dpath #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .AW    (AW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tag_id_i    (tag_id_i),
    .value_i     (value_i),
    .timestamp_i (timestamp_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .sts_o       (sts),
    .fill_o      (fill),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_o      (text_o),
    .last_o      (last_o)
  );

  // fill count never runs past the memory depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // an appended item bumps the fill count by one
  a_fill_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rec_en && !cmd.fill_clr |=> fill == $past(fill) + 1'b1)
    else $error("fill count did not advance on record");

  // dump reads only while the input is held off
  a_rd_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> in_stall_o && sts.rd_free)
    else $error("entry read outside dump or into busy stage");

  // no entry is appended while a dump is under way
  a_no_rec_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !cmd.rec_en && !cmd.fill_clr)
    else $error("buffer changed during dump");

endmodule

// ===== rtl/tetb_ctrl.sv =====
// Controller of the event trace buffer: input decode and dump sequencing.
module tetb_ctrl import tetb_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned CW    = $clog2(DEPTH + 1),
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [CW-1:0] fill_i,
  input  tetb_sts_t     sts_i,
  output tetb_cmd_t     cmd_o,
  output logic [AW-1:0] rd_addr_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e        state_q;
  logic [AW-1:0] rd_idx_q;
  logic [AW-1:0] end_idx_q;
  logic          accept;
  logic          is_rec;
  logic          is_flush;
  logic          rd_last;
  logic [CW-1:0] fill_m1;
  tetb_action_e  act;

  assign act        = tetb_action_e'(action_i);
  assign in_stall_o = (state_q == ST_DRAIN);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_rec     = (act == ACT_REC_VALUE) || (act == ACT_REC_TIME);
  assign is_flush   = (act == ACT_FLUSH);
  assign rd_last    = (rd_idx_q == end_idx_q);
  assign fill_m1    = fill_i - 1'b1;
  assign rd_addr_o  = rd_idx_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.rec_en   = accept && is_rec && sts_i.room;
    cmd_o.rec_ts   = (act == ACT_REC_TIME);
    cmd_o.fill_clr = accept && !is_rec;
    cmd_o.rd_en    = (state_q == ST_DRAIN) && sts_i.rd_free;
    cmd_o.rd_last  = rd_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_idx_q  <= '0;
      end_idx_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && is_flush && (fill_i != '0)) begin
            state_q   <= ST_DRAIN;
            rd_idx_q  <= '0;
            end_idx_q <= fill_m1[AW-1:0];
          end
        end
        ST_DRAIN: begin
          if (sts_i.rd_free) begin
            if (rd_last) state_q <= ST_IDLE;
            else         rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tetb_dpath.sv =====
// Datapath of the event trace buffer: entry memory, fill count, capacity, encoder, output.
module tetb_dpath import tetb_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned CW    = $clog2(DEPTH + 1),
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic [TAG_W-1:0]  tag_id_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] timestamp_i,
  input  tetb_cmd_t         cmd_i,
  input  logic [AW-1:0]     rd_addr_i,
  output tetb_sts_t         sts_o,
  output logic [CW-1:0]     fill_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TEXT_W-1:0] text_o,
  output logic              last_o
);

  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [CAP_W-1:0]   cap_q;
  logic [CW-1:0]      fill_q, fill_d;
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_last_q;
  logic               rd_vld_q, rd_vld_d;
  logic [TEXT_W-1:0]  text_q;
  logic               last_q;
  logic               out_vld_q, out_vld_d;
  logic               load_out;
  logic [DATA_W-1:0]  rec_word;

  assign rec_word    = cmd_i.rec_ts ? timestamp_i : value_i;
  assign sts_o.room  = (CMPW'(fill_q) < CMPW'(cap_q)) && (fill_q < CW'(DEPTH));
  assign load_out    = rd_vld_q && (!out_vld_q || !out_stall_i);
  assign sts_o.rd_free = !rd_vld_q || load_out;
  assign rd_vld_d    = cmd_i.rd_en || (rd_vld_q && !load_out);
  assign out_vld_d   = load_out || (out_vld_q && out_stall_i);
  assign fill_o      = fill_q;
  assign out_valid_o = out_vld_q;
  assign text_o      = text_q;
  assign last_o      = last_q;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr)    fill_d = '0;
    else if (cmd_i.rec_en) fill_d = fill_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      fill_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      fill_q    <= fill_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_en) mem[fill_q[AW-1:0]] <= {rec_word, tag_id_i};
    if (cmd_i.rd_en) begin
      rd_q      <= mem[rd_addr_i];
      rd_last_q <= cmd_i.rd_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      text_q <= b64_encode(rd_q);
      last_q <= rd_last_q;
    end
  end

endmodule
